### rtl/gcd_lcm_unit_defines.svh
// ----------------------------------------------------------------------------
// gcd_lcm_unit_defines.svh
// Assertion macros shared by the GCD/LCM unit.
// ----------------------------------------------------------------------------
`ifndef GCD_LCM_UNIT_DEFINES_SVH
`define GCD_LCM_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GLU_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GLU_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("%m: assertion failed");

`endif

### rtl/glu_pkg.sv
// ----------------------------------------------------------------------------
// glu_pkg
// Types and constants of the GCD/LCM unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package glu_pkg;

  // Operand bits that take part in the math; port fields are always 32 bits.
  localparam int unsigned OperandWidth = 32;
  localparam int unsigned PortWidth    = 32;
  localparam int unsigned ShiftWidth   = $clog2(OperandWidth);
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned PtrWidth     = $clog2(QueueDepth);
  localparam int unsigned FillWidth    = $clog2(QueueDepth + 1);

  typedef logic [OperandWidth-1:0] opnd_t;

  typedef struct packed {
    logic [PortWidth-1:0] operand_a;
    logic [PortWidth-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic [PortWidth-1:0]   divisor;
    logic [2*PortWidth-1:0] multiple;
    logic                   both_zero;
  } rsp_t;

  typedef enum logic [1:0] {
    KIND_GENERAL,
    KIND_ONE_ZERO,
    KIND_BOTH_ZERO
  } kind_e;

  typedef struct packed {
    opnd_t a;
    opnd_t b;
    kind_e kind;
  } job_t;

  // Write side of the job queue.
  typedef struct packed {
    logic valid;
    job_t job;
  } q_wr_t;

  // Read side of the job queue.
  typedef struct packed {
    logic empty;
    job_t job;
  } q_rd_t;

endpackage

### rtl/gcd_lcm_unit.sv
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// Greatest common divisor and least common multiple of two unsigned operands.
// ----------------------------------------------------------------------------
// Push a request (operand_a, operand_b) while full is low; one response
// (divisor, multiple, both_zero) per request comes out in request order and
// is taken with pop while empty is low. Operand bits above
// glu_pkg::OperandWidth are ignored. If either operand is zero the multiple
// is zero and the divisor is the other operand; if both are zero, both
// results are zero and both_zero is set. A request with a zero operand
// leaves the head of the request queue once the back end is idle and the
// response register is free or being popped, and its response is
// registered as it leaves. Any other request leaves the queue once the
// back end is idle, runs a binary GCD loop of one compare/subtract/shift
// per cycle, then a restoring divide of operand_a by the divisor (W
// quotient bits, W = OperandWidth, one per cycle), then the 32x32 multiply
// into the response register, which waits while an earlier response has
// not been popped.
// The back end handles one request at a time; a two-entry request queue
// in front lets new requests come in while it works, and the response
// register lets a general request start while a response waits for pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcd_lcm_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  // request side
  input  logic          push,
  output logic          full,
  input  glu_pkg::req_t req_i,
  // response side
  output logic          empty,
  input  logic          pop,
  output glu_pkg::rsp_t rsp_o
);

  glu_pkg::q_wr_t q_wr;
  glu_pkg::q_rd_t q_rd;
  logic           q_full;
  logic           q_pop;

  // Front end: narrows operands and tags the zero cases.
  glu_front u_front (
    .push     (push),
    .full     (full),
    .req_i    (req_i),
    .q_full_i (q_full),
    .q_wr_o   (q_wr)
  );

  // Decoupling queue between front and back.
  glu_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_wr_i   (q_wr),
    .q_full_o (q_full),
    .q_pop_i  (q_pop),
    .q_rd_o   (q_rd)
  );

  // Back end: GCD loop, divide, multiply and the response register.
  glu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_rd_i  (q_rd),
    .q_pop_o (q_pop),
    .empty   (empty),
    .pop     (pop),
    .rsp_o   (rsp_o)
  );

endmodule

### rtl/glu_front.sv
// ----------------------------------------------------------------------------
// glu_front
// Accepts requests, narrows the operands and classifies zero cases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glu_front (
  input  logic           push,
  output logic           full,
  input  glu_pkg::req_t  req_i,
  input  logic           q_full_i,
  output glu_pkg::q_wr_t q_wr_o
);

  glu_pkg::opnd_t a;
  glu_pkg::opnd_t b;

  assign a = req_i.operand_a[glu_pkg::OperandWidth-1:0];
  assign b = req_i.operand_b[glu_pkg::OperandWidth-1:0];

  always_comb begin
    q_wr_o.valid = push && !q_full_i;
    q_wr_o.job.a = a;
    q_wr_o.job.b = b;
    if ((a == '0) && (b == '0)) begin
      q_wr_o.job.kind = glu_pkg::KIND_BOTH_ZERO;
    end else if ((a == '0) || (b == '0)) begin
      q_wr_o.job.kind = glu_pkg::KIND_ONE_ZERO;
    end else begin
      q_wr_o.job.kind = glu_pkg::KIND_GENERAL;
    end
  end

  assign full = q_full_i;

endmodule

### rtl/glu_fifo.sv
// ----------------------------------------------------------------------------
// glu_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glu_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  glu_pkg::q_wr_t q_wr_i,
  output logic           q_full_o,
  input  logic           q_pop_i,
  output glu_pkg::q_rd_t q_rd_o
);

  glu_pkg::job_t                      slot_q [glu_pkg::QueueDepth];
  logic [glu_pkg::PtrWidth-1:0]       wr_ptr_q, wr_ptr_d;
  logic [glu_pkg::PtrWidth-1:0]       rd_ptr_q, rd_ptr_d;
  logic [glu_pkg::FillWidth-1:0]      fill_q, fill_d;
  logic                               do_wr;
  logic                               do_rd;

  assign q_full_o = (fill_q == glu_pkg::FillWidth'(glu_pkg::QueueDepth));
  assign do_wr    = q_wr_i.valid && !q_full_o;
  assign do_rd    = q_pop_i && (fill_q != '0);

  assign q_rd_o.empty = (fill_q == '0);
  assign q_rd_o.job   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == glu_pkg::PtrWidth'(glu_pkg::QueueDepth - 1)) ? '0
                                                                         : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == glu_pkg::PtrWidth'(glu_pkg::QueueDepth - 1)) ? '0
                                                                         : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      fill_d = fill_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= q_wr_i.job;
    end
  end

endmodule

### rtl/glu_back.sv
// ----------------------------------------------------------------------------
// glu_back
// Binary GCD loop, bit-serial exact division, final multiply, result slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gcd_lcm_unit_defines.svh"

module glu_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  glu_pkg::q_rd_t q_rd_i,
  output logic           q_pop_o,
  output logic           empty,
  input  logic           pop,
  output glu_pkg::rsp_t  rsp_o
);

  localparam int unsigned W = glu_pkg::OperandWidth;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MUL
  } state_e;

  state_e                         state_q, state_d;
  glu_pkg::opnd_t                 a_q, a_d;
  glu_pkg::opnd_t                 b_q, b_d;
  glu_pkg::opnd_t                 x_q, x_d;
  glu_pkg::opnd_t                 y_q, y_d;
  glu_pkg::opnd_t                 g_q, g_d;
  glu_pkg::opnd_t                 quo_q, quo_d;
  glu_pkg::opnd_t                 rem_q, rem_d;
  logic [glu_pkg::ShiftWidth-1:0] k_q, k_d;
  logic [glu_pkg::ShiftWidth-1:0] cnt_q, cnt_d;
  glu_pkg::rsp_t                  res_q, res_d;
  logic                           res_valid_q, res_valid_d;

  logic                           slot_free;
  logic [W:0]                     rem_sh;
  logic                           rem_ge;

  assign slot_free = !res_valid_q || pop;
  assign q_pop_o   = (state_q == ST_IDLE) && !q_rd_i.empty &&
                     ((q_rd_i.job.kind == glu_pkg::KIND_GENERAL) || slot_free);

  assign rem_sh = {rem_q, quo_q[W-1]};
  assign rem_ge = (rem_sh >= {1'b0, g_q});

  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    x_d         = x_q;
    y_d         = y_q;
    g_d         = g_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !pop;

    unique case (state_q)
      ST_IDLE: begin
        if (q_pop_o) begin
          case (q_rd_i.job.kind)
            glu_pkg::KIND_GENERAL: begin
              a_d     = q_rd_i.job.a;
              b_d     = q_rd_i.job.b;
              x_d     = q_rd_i.job.a;
              y_d     = q_rd_i.job.b;
              k_d     = '0;
              state_d = ST_GCD;
            end
            default: begin
              // One operand zero: the divisor is the other one.
              // Both zero: everything is zero and the flag is set.
              res_d.divisor   = glu_pkg::PortWidth'(q_rd_i.job.a | q_rd_i.job.b);
              res_d.multiple  = '0;
              res_d.both_zero = (q_rd_i.job.kind == glu_pkg::KIND_BOTH_ZERO);
              res_valid_d     = 1'b1;
            end
          endcase
        end
      end

      ST_GCD: begin
        if (a_q == '0) begin
          g_d     = b_q << k_q;
          quo_d   = x_q;
          rem_d   = '0;
          cnt_d   = glu_pkg::ShiftWidth'(W - 1);
          state_d = ST_DIV;
        end else if (b_q == '0) begin
          g_d     = a_q << k_q;
          quo_d   = x_q;
          rem_d   = '0;
          cnt_d   = glu_pkg::ShiftWidth'(W - 1);
          state_d = ST_DIV;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (a_q >= b_q) begin
          a_d = (a_q - b_q) >> 1;
        end else begin
          b_d = (b_q - a_q) >> 1;
        end
      end

      ST_DIV: begin
        // Restoring division of x by the divisor, one quotient bit a cycle.
        // The remainder stays below the divisor, so W bits hold it.
        rem_d = rem_ge ? W'(rem_sh - {1'b0, g_q}) : rem_sh[W-1:0];
        quo_d = {quo_q[W-2:0], rem_ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_MUL;
        end
      end

      ST_MUL: begin
        if (slot_free) begin
          res_d.divisor   = glu_pkg::PortWidth'(g_q);
          res_d.multiple  = (2 * glu_pkg::PortWidth)'(quo_q * y_q);
          res_d.both_zero = 1'b0;
          res_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      a_q         <= '0;
      b_q         <= '0;
      x_q         <= '0;
      y_q         <= '0;
      g_q         <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      k_q         <= '0;
      cnt_q       <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      a_q         <= a_d;
      b_q         <= b_d;
      x_q         <= x_d;
      y_q         <= y_d;
      g_q         <= g_d;
      quo_q       <= quo_d;
      rem_q       <= rem_d;
      k_q         <= k_d;
      cnt_q       <= cnt_d;
      res_q       <= res_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign empty = !res_valid_q;
  assign rsp_o = res_q;

  `GLU_ASSERT_IMPLY(a_gcd_not_both_zero, clk_i, rst_ni, state_q == ST_GCD,
                    (a_q != '0) || (b_q != '0))
  `GLU_ASSERT_IMPLY(a_div_by_nonzero, clk_i, rst_ni, state_q == ST_DIV, g_q != '0)
  `GLU_ASSERT_IMPLY(a_zero_flag_result, clk_i, rst_ni, res_valid_q && res_q.both_zero,
                    (res_q.divisor == '0) && (res_q.multiple == '0))
  `GLU_ASSERT_NEXT(a_general_starts_gcd, clk_i, rst_ni,
                   q_pop_o && (q_rd_i.job.kind == glu_pkg::KIND_GENERAL),
                   state_q == ST_GCD)

endmodule
